### hw/rtl/ec_point_add_double_modp_top_macros.svh
// Assertion macros shared by the point arithmetic block.
`ifndef EC_POINT_ADD_DOUBLE_MODP_TOP_MACROS_SVH
`define EC_POINT_ADD_DOUBLE_MODP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ECPA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ECPA_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECPA_ASSERT(lbl, clk, rstn, prop, msg)
`define ECPA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// ecpa_pkg
// Types, opcodes and microprogram for the point add/double sequencer.
// ----------------------------------------------------------------------------
package ecpa_pkg;

  localparam int REG_W = 16;

  typedef struct packed {
    logic        command;
    logic [15:0] p_x;
    logic [15:0] p_y;
    logic [15:0] q_x;
    logic [15:0] q_y;
  } ecpa_in_t;

  typedef struct packed {
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic        at_infinity;
  } ecpa_out_t;

  localparam logic CMD_DOUBLE = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  localparam logic CFG_PRIME = 1'b0;
  localparam logic CFG_COEFF = 1'b1;

  // Register file addresses
  typedef enum logic [3:0] {
    R_PX, R_PY, R_QX, R_QY, R_A, R_NUM, R_DEN, R_T,
    R_INV, R_BASE, R_S, R_X3, R_Y3, R_ONE, R_ZERO, R_E
  } ecpa_reg_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_RED, OP_JMP, OP_INV, OP_DONE
  } ecpa_op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_ALWAYS, JC_DBL, JC_DEN0, JC_NONE
  } ecpa_jc_t;

  typedef struct packed {
    ecpa_op_t  op;
    ecpa_reg_t dst;
    ecpa_reg_t src_a;
    ecpa_reg_t src_b;
    ecpa_jc_t  jc;
    logic [4:0] target;
  } ecpa_uword_t;

  typedef struct packed {
    logic start;
    ecpa_op_t op;
  } ecpa_alu_req_t;

  localparam int PC_W = 5;

  function automatic ecpa_uword_t ucode(input logic [PC_W-1:0] pc);
    ecpa_uword_t w;
    w = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO, JC_NONE, 5'd0};
    unique case (pc)
      5'd0:  w = '{OP_RED, R_PX, R_PX, R_ZERO, JC_NONE, 5'd0};
      5'd1:  w = '{OP_RED, R_PY, R_PY, R_ZERO, JC_NONE, 5'd0};
      5'd2:  w = '{OP_RED, R_QX, R_QX, R_ZERO, JC_NONE, 5'd0};
      5'd3:  w = '{OP_RED, R_QY, R_QY, R_ZERO, JC_NONE, 5'd0};
      5'd4:  w = '{OP_RED, R_A, R_A, R_ZERO, JC_NONE, 5'd0};
      5'd5:  w = '{OP_JMP, R_ZERO, R_ZERO, R_ZERO, JC_DBL, 5'd9};
      5'd6:  w = '{OP_SUB, R_NUM, R_QY, R_PY, JC_NONE, 5'd0};
      5'd7:  w = '{OP_SUB, R_DEN, R_QX, R_PX, JC_NONE, 5'd0};
      5'd8:  w = '{OP_JMP, R_ZERO, R_ZERO, R_ZERO, JC_ALWAYS, 5'd16};
      5'd9:  w = '{OP_MUL, R_T, R_PX, R_PX, JC_NONE, 5'd0};
      5'd10: w = '{OP_ADD, R_NUM, R_T, R_T, JC_NONE, 5'd0};
      5'd11: w = '{OP_ADD, R_NUM, R_NUM, R_T, JC_NONE, 5'd0};
      5'd12: w = '{OP_ADD, R_NUM, R_NUM, R_A, JC_NONE, 5'd0};
      5'd13: w = '{OP_ADD, R_DEN, R_PY, R_PY, JC_NONE, 5'd0};
      5'd14: w = '{OP_ADD, R_QX, R_PX, R_ZERO, JC_NONE, 5'd0};
      5'd15: w = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO, JC_NONE, 5'd0};
      5'd16: w = '{OP_JMP, R_ZERO, R_ZERO, R_ZERO, JC_DEN0, 5'd26};
      5'd17: w = '{OP_INV, R_INV, R_DEN, R_E, JC_NONE, 5'd0};
      5'd18: w = '{OP_MUL, R_S, R_NUM, R_INV, JC_NONE, 5'd0};
      5'd19: w = '{OP_MUL, R_T, R_S, R_S, JC_NONE, 5'd0};
      5'd20: w = '{OP_SUB, R_T, R_T, R_PX, JC_NONE, 5'd0};
      5'd21: w = '{OP_SUB, R_X3, R_T, R_QX, JC_NONE, 5'd0};
      5'd22: w = '{OP_SUB, R_T, R_PX, R_X3, JC_NONE, 5'd0};
      5'd23: w = '{OP_MUL, R_T, R_S, R_T, JC_NONE, 5'd0};
      5'd24: w = '{OP_SUB, R_Y3, R_T, R_PY, JC_NONE, 5'd0};
      5'd25: w = '{OP_DONE, R_ZERO, R_ZERO, R_ZERO, JC_NONE, 5'd0};
      5'd26: w = '{OP_DONE, R_ZERO, R_ZERO, R_ZERO, JC_NONE, 5'd0};
      default: w = '{OP_DONE, R_ZERO, R_ZERO, R_ZERO, JC_NONE, 5'd0};
    endcase
    return w;
  endfunction

  localparam logic [PC_W-1:0] PC_FINISH = 5'd25;
  localparam logic [PC_W-1:0] PC_INF    = 5'd26;

endpackage

### hw/rtl/ecpa_alu.sv
// ----------------------------------------------------------------------------
// ecpa_alu
// Modular add/sub, bit-serial reduce, double-and-add multiply, Fermat inverse.
// ----------------------------------------------------------------------------
module ecpa_alu import ecpa_pkg::*; #(
  parameter int FIELD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecpa_alu_req_t         req,
  input  logic [FIELD_BITS-1:0] a,
  input  logic [FIELD_BITS-1:0] b,
  input  logic [FIELD_BITS-1:0] m,
  output logic                  done,
  output logic [FIELD_BITS-1:0] res
);

  localparam int CW = $clog2(FIELD_BITS + 1);
  localparam int W1 = FIELD_BITS + 1;

  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_INVM, S_INVS} st_t;

  st_t                  st_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        icnt_r;
  logic [FIELD_BITS-1:0] acc_r, x_r, y_r, inv_r, base_r, exp_r;
  logic [FIELD_BITS-1:0] res_r;
  logic                  done_r;
  logic                  inv_mode_r;
  logic                  sq_r;

  function automatic logic [FIELD_BITS-1:0] addm(input logic [FIELD_BITS-1:0] x,
      input logic [FIELD_BITS-1:0] y, input logic [FIELD_BITS-1:0] mm);
    logic [W1-1:0] s;
    logic [W1-1:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, mm};
    return (s >= {1'b0, mm}) ? d[FIELD_BITS-1:0] : s[FIELD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] subm(input logic [FIELD_BITS-1:0] x,
      input logic [FIELD_BITS-1:0] y, input logic [FIELD_BITS-1:0] mm);
    return (x >= y) ? (x - y) : (x + (mm - y));
  endfunction

  // One double-and-add step of acc*2 + (bit ? x : 0)
  logic [FIELD_BITS-1:0] dbl_w, step_w;
  logic                  ybit_w;
  logic [FIELD_BITS-1:0] cnt_idx_w;
  always_comb begin
    cnt_idx_w = FIELD_BITS'(cnt_r - CW'(1));
    ybit_w    = y_r[cnt_idx_w[$clog2(FIELD_BITS)-1:0]];
    dbl_w     = addm(acc_r, acc_r, m);
    step_w    = ybit_w ? addm(dbl_w, x_r, m) : dbl_w;
  end

  // Restoring reduce: shift in one bit of x at a time
  logic [W1-1:0]         rsh_w;
  logic [FIELD_BITS-1:0] red_w;
  always_comb begin
    rsh_w = {acc_r, x_r[cnt_idx_w[$clog2(FIELD_BITS)-1:0]]};
    red_w = (rsh_w >= {1'b0, m}) ? FIELD_BITS'(rsh_w - {1'b0, m})
                                 : rsh_w[FIELD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
      icnt_r <= '0;
      inv_mode_r <= 1'b0;
      sq_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (req.start) begin
            x_r   <= a;
            y_r   <= b;
            acc_r <= '0;
            cnt_r <= CW'(FIELD_BITS);
            unique case (req.op)
              OP_ADD: begin res_r <= addm(a, b, m); done_r <= 1'b1; end
              OP_SUB: begin res_r <= subm(a, b, m); done_r <= 1'b1; end
              OP_RED: st_r <= S_RED;
              OP_MUL: begin st_r <= S_MUL; inv_mode_r <= 1'b0; end
              OP_INV: begin
                base_r <= a;
                exp_r  <= b;
                inv_r  <= (m == FIELD_BITS'(1)) ? '0 : FIELD_BITS'(1);
                icnt_r <= '0;
                st_r   <= S_INVS;
              end
              default: begin res_r <= a; done_r <= 1'b1; end
            endcase
          end
        end
        S_RED: begin
          acc_r <= red_w;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            res_r <= red_w; done_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        S_MUL: begin
          acc_r <= step_w;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            if (inv_mode_r) begin
              if (sq_r) begin
                base_r <= step_w;
                exp_r  <= exp_r >> 1;
                icnt_r <= icnt_r + CW'(1);
                st_r   <= S_INVS;
              end else begin
                inv_r  <= step_w;
                // now square the base
                x_r <= base_r; y_r <= base_r; acc_r <= '0;
                cnt_r <= CW'(FIELD_BITS);
                sq_r  <= 1'b1;
              end
            end else begin
              res_r <= step_w; done_r <= 1'b1; st_r <= S_IDLE;
            end
          end
        end
        S_INVS: begin
          // Fermat: walk exponent bits LSB first
          if (icnt_r == CW'(FIELD_BITS)) begin
            res_r <= inv_r; done_r <= 1'b1; st_r <= S_IDLE;
          end else begin
            inv_mode_r <= 1'b1;
            acc_r <= '0;
            cnt_r <= CW'(FIELD_BITS);
            st_r  <= S_MUL;
            sq_r  <= !exp_r[0];
            if (exp_r[0]) begin
              x_r <= inv_r; y_r <= base_r;
            end else begin
              x_r <= base_r; y_r <= base_r;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### hw/rtl/ec_point_add_double_modp_top.sv
// ----------------------------------------------------------------------------
// ec_point_add_double_modp_top
// Affine point doubling / addition mod p, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one command beat (double P or add P+Q); out_valid/
//   out_stall carry one result beat (r_x, r_y, at_infinity) per command.
//   cfg_we/cfg_index/cfg_data write the modulus (index 0, reset 17) and the
//   coefficient a (index 1, reset 2); the user writes them only while the
//   block is idle, which the block itself does not enforce. One command at
//   a time: the step counter walks a 27-word program. Each multiply or reduce
//   is bit-serial; the Fermat inverse squares the base for every bit of p-2
//   and multiplies once more per set bit. A zero denominator skips the
//   inverse and gives the point at infinity.
//   Reset (synchronous rst_n) restores the register defaults and idles.
//   The result is held in an output register; while out_stall is high it
//   stays put and no new command is taken.
// ----------------------------------------------------------------------------
`include "ec_point_add_double_modp_top_macros.svh"
module ec_point_add_double_modp_top import ecpa_pkg::*; #(
  parameter int FIELD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ecpa_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ecpa_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int FW = FIELD_BITS;

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_WAIT, ST_OUT} st_t;

  st_t              st_r;
  logic [PC_W-1:0]  pc_r;
  logic [15:0]      prime_r, coeff_r;
  logic [FW-1:0]    rf_r [16];
  logic             dbl_r;
  ecpa_out_t        out_r;
  ecpa_alu_req_t    req;
  logic             alu_done;
  logic [FW-1:0]    alu_res;
  logic [FW-1:0]    m_w;
  ecpa_uword_t      uw;
  logic             out_inf_w;
  logic             out_zero_w;

  function automatic logic [FW-1:0] fit(input logic [15:0] v);
    logic [FW+15:0] t;
    t = {{FW{1'b0}}, v};
    return t[FW-1:0];
  endfunction

  function automatic logic [15:0] unfit(input logic [FW-1:0] v);
    logic [FW+15:0] t;
    t = {16'd0, v};
    return t[15:0];
  endfunction

  assign m_w = fit(prime_r);
  assign uw  = ucode(pc_r);

  assign req.start = (st_r == ST_FETCH) && (uw.op == OP_ADD || uw.op == OP_SUB ||
                     uw.op == OP_MUL || uw.op == OP_RED || uw.op == OP_INV);
  assign req.op    = uw.op;

  ecpa_alu #(.FIELD_BITS(FIELD_BITS)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .a    (rf_r[uw.src_a]),
    .b    (rf_r[uw.src_b]),
    .m    (m_w),
    .done (alu_done),
    .res  (alu_res)
  );

  logic take_jump;
  always_comb begin
    unique case (uw.jc)
      JC_ALWAYS: take_jump = 1'b1;
      JC_DBL:    take_jump = dbl_r;
      JC_DEN0:   take_jump = (rf_r[R_DEN] == '0);
      default:   take_jump = 1'b0;
    endcase
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_data  = out_r;

  assign out_inf_w  = out_valid && out_data.at_infinity;
  assign out_zero_w = (out_data.r_x == '0) && (out_data.r_y == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      pc_r    <= '0;
      prime_r <= 16'd17;
      coeff_r <= 16'd2;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PRIME) prime_r <= cfg_data;
        else                        coeff_r <= cfg_data;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            rf_r[R_PX] <= fit(in_data.p_x);
            rf_r[R_PY] <= fit(in_data.p_y);
            rf_r[R_QX] <= fit(in_data.q_x);
            rf_r[R_QY] <= fit(in_data.q_y);
            rf_r[R_A]  <= fit(coeff_r);
            rf_r[R_ZERO] <= '0;
            rf_r[R_ONE]  <= FW'(1);
            rf_r[R_E]    <= m_w - FW'(2);
            dbl_r <= (in_data.command == CMD_DOUBLE);
            pc_r  <= '0;
            if (prime_r < 16'd2) begin
              out_r <= '0;
              st_r  <= ST_OUT;
            end else begin
              st_r <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          priority case (uw.op)
            OP_DONE: begin
              out_r.r_x <= (pc_r == PC_INF) ? '0 : unfit(rf_r[R_X3]);
              out_r.r_y <= (pc_r == PC_INF) ? '0 : unfit(rf_r[R_Y3]);
              out_r.at_infinity <= (pc_r == PC_INF);
              st_r <= ST_OUT;
            end
            OP_JMP:  pc_r <= take_jump ? uw.target : pc_r + PC_W'(1);
            OP_NOP:  pc_r <= pc_r + PC_W'(1);
            default: st_r <= ST_WAIT;
          endcase
        end
        ST_WAIT: begin
          if (alu_done) begin
            rf_r[uw.dst] <= alu_res;
            pc_r <= pc_r + PC_W'(1);
            st_r <= ST_FETCH;
          end
        end
        ST_OUT: begin
          if (!out_stall) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `ECPA_ASSERT(a_busy_no_take, clk, rst_n, (st_r != ST_IDLE) |-> in_stall, "accept while busy")
  `ECPA_ASSERT(a_inf_zero, clk, rst_n, out_inf_w |-> out_zero_w, "infinity with nonzero coords")
  `ECPA_ASSERT(a_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "result dropped under stall")
  `ECPA_ASSERT(a_pc_range, clk, rst_n, (st_r == ST_FETCH) |-> (pc_r <= PC_INF), "pc ran off program")

endmodule

### test/tb_ec_point_add_double_modp_top.sv
// ----------------------------------------------------------------------------
// tb_ec_point_add_double_modp_top
// Self-checking bench for affine point add/double mod p: a queue-fed driver
// offers command beats, a monitor compares every result beat with a point
// computed by the bench's own modular arithmetic, across several moduli.
// ----------------------------------------------------------------------------
module tb_ec_point_add_double_modp_top import ecpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBITS = 16;
  localparam int STALL_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ecpa_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  ecpa_out_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  ec_point_add_double_modp_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0] modulus;
  logic [15:0] coeff_a;

  ecpa_in_t  cmd_queue[$];
  ecpa_out_t point_queue[$];
  int        errors;
  int        idle_cycles;
  bit        calm;
  bit        hold_long;
  int        tx_gap;
  int        rx_gap;
  int        hold_cnt;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [16:0] fadd(logic [16:0] x, logic [16:0] y, logic [16:0] m);
    logic [16:0] room;
    room = m - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  function automatic logic [16:0] fsub(logic [16:0] x, logic [16:0] y, logic [16:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  function automatic logic [16:0] fmul(logic [16:0] x, logic [16:0] y, logic [16:0] m);
    logic [16:0] r;
    r = '0;
    for (int i = NBITS - 1; i >= 0; i--) begin
      r = fadd(r, r, m);
      if (y[i]) r = fadd(r, x, m);
    end
    return r;
  endfunction

  function automatic logic [16:0] finv(logic [16:0] d, logic [16:0] m);
    logic [16:0] e, r, b;
    e = m - 17'd2;
    r = 17'd1 % m;
    b = d;
    for (int i = 0; i < NBITS; i++) begin
      if (e[i]) r = fmul(r, b, m);
      b = fmul(b, b, m);
    end
    return r;
  endfunction

  function automatic ecpa_out_t point_op(ecpa_in_t c);
    ecpa_out_t   o;
    logic [16:0] m, px, py, qx, qy, a, num, den, sq, s, x3, y3;
    o = '0;
    m = {1'b0, modulus};
    if (m < 2) return o;
    px = {1'b0, c.p_x} % m;
    py = {1'b0, c.p_y} % m;
    qx = {1'b0, c.q_x} % m;
    qy = {1'b0, c.q_y} % m;
    a = {1'b0, coeff_a} % m;
    if (c.command == CMD_DOUBLE) begin
      sq = fmul(px, px, m);
      num = fadd(fadd(fadd(sq, sq, m), sq, m), a, m);
      den = fadd(py, py, m);
      qx = px;
    end else begin
      num = fsub(qy, py, m);
      den = fsub(qx, px, m);
    end
    if (den == 0) begin
      o.at_infinity = 1'b1;
      return o;
    end
    s = fmul(num, finv(den, m), m);
    x3 = fsub(fsub(fmul(s, s, m), px, m), qx, m);
    y3 = fsub(fmul(s, fsub(px, x3, m), m), py, m);
    o.r_x = x3[15:0];
    o.r_y = y3[15:0];
    return o;
  endfunction

  // driver: random gaps between beats, none once calm is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) point_queue.push_back(point_op(in_data));
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_data <= cmd_queue.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    ecpa_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (point_queue.size() == 0) begin
          $error("result beat with no expected point");
          errors++;
        end else begin
          want = point_queue.pop_front();
          if (out_data.r_x !== want.r_x) begin
            $error("r_x expected %0d actual %0d", want.r_x, out_data.r_x);
            errors++;
          end
          if (out_data.r_y !== want.r_y) begin
            $error("r_y expected %0d actual %0d", want.r_y, out_data.r_y);
            errors++;
          end
          if (out_data.at_infinity !== want.at_infinity) begin
            $error("at_infinity expected %0d actual %0d", want.at_infinity,
                   out_data.at_infinity);
            errors++;
          end
        end
      end
      if (hold_long && hold_cnt < 4000) begin
        hold_cnt <= hold_cnt + 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rx_gap <= $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL ec_point_add_double_modp_top");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRIME) modulus = val;
    else coeff_a = val;
  endtask

  // sample between edges so the driver's updates have settled
  task automatic drain_all();
    while (cmd_queue.size() != 0 || in_valid || point_queue.size() != 0)
      @(negedge clk);
    repeat (1000) @(posedge clk);
  endtask

  function automatic logic [15:0] below_mod();
    if (modulus < 2) return 16'($urandom);
    return 16'($urandom_range(0, modulus - 1));
  endfunction

  task automatic push_cmd(logic op, logic [15:0] px, logic [15:0] py,
                          logic [15:0] qx, logic [15:0] qy);
    ecpa_in_t c;
    c.command = op;
    c.p_x = px;
    c.p_y = py;
    c.q_x = qx;
    c.q_y = qy;
    cmd_queue.push_back(c);
  endtask

  task automatic random_cmds(int n);
    logic [15:0] px, py;
    int          k;
    for (int i = 0; i < n; i++) begin
      px = below_mod();
      py = below_mod();
      k = $urandom_range(0, 19);
      if (k == 0) push_cmd(CMD_ADD, px, py, px, below_mod());
      else if (k == 1) push_cmd(CMD_DOUBLE, px, 16'd0, below_mod(), below_mod());
      else if (k < 4) push_cmd(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
      else push_cmd(1'($urandom_range(0, 1)), px, py, below_mod(), below_mod());
    end
  endtask

  initial begin
    logic [15:0] primes[6];
    primes = '{16'd65521, 16'd3, 16'd251, 16'd65519, 16'd10007, 16'd97};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PRIME;
    cfg_data = '0;
    modulus = 16'd17;
    coeff_a = 16'd2;
    errors = 0;
    calm = 1'b0;
    hold_long = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed at reset values: double, add, infinity cases, unreduced inputs
    push_cmd(CMD_DOUBLE, 16'd5, 16'd1, 16'd0, 16'd0);
    push_cmd(CMD_ADD, 16'd5, 16'd1, 16'd6, 16'd3);
    push_cmd(CMD_DOUBLE, 16'd3, 16'd0, 16'hFFFF, 16'hFFFF);
    push_cmd(CMD_ADD, 16'd4, 16'd7, 16'd4, 16'd7);
    push_cmd(CMD_ADD, 16'd4, 16'd7, 16'd21, 16'd2);
    push_cmd(CMD_DOUBLE, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    push_cmd(CMD_ADD, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    push_cmd(CMD_ADD, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_cmd(CMD_DOUBLE, 16'd0, 16'd17, 16'd0, 16'd0);
    drain_all();

    write_reg(CFG_COEFF, 16'hFFFF);
    push_cmd(CMD_DOUBLE, 16'd2, 16'd3, 16'd0, 16'd0);
    push_cmd(CMD_DOUBLE, 16'h5555, 16'hAAAA, 16'd0, 16'd0);
    drain_all();

    // modulus below two, then a composite modulus
    write_reg(CFG_PRIME, 16'd1);
    push_cmd(CMD_DOUBLE, 16'd1, 16'd1, 16'd0, 16'd0);
    push_cmd(CMD_ADD, 16'd1, 16'd2, 16'd3, 16'd4);
    drain_all();
    write_reg(CFG_PRIME, 16'd0);
    push_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    drain_all();
    write_reg(CFG_PRIME, 16'hFFFF);
    push_cmd(CMD_ADD, 16'd1, 16'd2, 16'd3, 16'd4);
    push_cmd(CMD_DOUBLE, 16'hFFFE, 16'h1234, 16'd0, 16'd0);
    drain_all();

    // receiver holds off long while the sender keeps offering
    write_reg(CFG_PRIME, 16'd65521);
    write_reg(CFG_COEFF, 16'd0);
    hold_long = 1'b1;
    random_cmds(6);
    drain_all();
    hold_long = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_PRIME, primes[ph]);
      write_reg(CFG_COEFF, (ph % 2) ? 16'($urandom) : below_mod());
      if (ph == 5) calm = 1'b1;
      random_cmds(120);
      drain_all();
    end

    if (errors == 0) begin
      $display("PASS ec_point_add_double_modp_top");
    end else begin
      $display("FAIL ec_point_add_double_modp_top");
    end
    $finish;
  end
endmodule
